>>> sv/cfrr_pkg.sv
// Shared types and constants for the checksum frame receiver / re-framer.
// No dependencies; imported by every module of the block except cfrr_checker.
`default_nettype none

package cfrr_pkg;

  // Byte position inside a received frame that carries the route flag
  localparam int unsigned ROUTE_IDX = 13;
  // Bit of that byte that selects the wired link
  localparam int unsigned ROUTE_BIT = 7;
  // Reset value of both start-byte registers
  localparam logic [7:0] START_RESET = 8'hA5;

  // Configuration register indexes
  localparam logic CFG_IN_START  = 1'b0;
  localparam logic CFG_OUT_START = 1'b1;

  // Depth of the frame descriptor queue; also the number of frame slots
  localparam int unsigned DESC_DEPTH = 2;

  // One checked frame waiting to be emitted
  typedef struct packed {
    logic slot;   // frame buffer slot holding the frame
    logic route;  // route flag of the frame
  } desc_t;

  // Status of the emitter toward the top level
  typedef struct packed {
    logic busy;   // a frame slot is held by the emitter
  } bk_stat_t;

endpackage

`default_nettype wire

>>> sv/cfrr_front.sv
// Receive side: start-byte hunt, frame capture into the frame buffer, checksum test.
// Depends on cfrr_pkg.
`default_nettype none

module cfrr_front
  import cfrr_pkg::*;
#(
  parameter int IN_LEN = 16,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              rx_valid_i,
  output logic                   rx_ready_o,
  input  wire logic              slot_free_i,
  input  wire logic [7:0]        in_start_i,
  output logic                   wr_en_o,
  output logic [ADDR_W-1:0]      wr_addr_o,
  output logic [7:0]             wr_data_o,
  output logic                   push_o,
  output desc_t                  push_desc_o
);

  localparam int POS_W = $clog2(IN_LEN);

  typedef enum logic [1:0] {
    FR_HUNT    = 2'b01,
    FR_COLLECT = 2'b10
  } fr_state_e;

  fr_state_e        state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic             slot_q, slot_d;
  logic             route_q, route_d;
  logic             accept;
  logic             at_last;
  logic             pass;

  assign rx_ready_o = slot_free_i;
  assign accept     = rx_valid_i & rx_ready_o;
  assign at_last    = (pos_q == POS_W'(IN_LEN - 1));
  assign pass       = (rx_byte_i == sum_q);

  assign wr_en_o   = accept & ((state_q == FR_COLLECT) | (rx_byte_i == in_start_i));
  assign wr_addr_o = ADDR_W'(pos_q) + (slot_q ? ADDR_W'(IN_LEN) : '0);
  assign wr_data_o = rx_byte_i;

  assign push_o            = accept & (state_q == FR_COLLECT) & at_last & pass;
  assign push_desc_o.slot  = slot_q;
  assign push_desc_o.route = route_q;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    slot_d  = slot_q;
    route_d = route_q;
    case (state_q)
      FR_HUNT: begin
        if (accept && (rx_byte_i == in_start_i)) begin
          sum_d   = rx_byte_i;
          pos_d   = POS_W'(1);
          state_d = FR_COLLECT;
        end
      end
      FR_COLLECT: begin
        if (accept) begin
          if (at_last) begin
            // Frame complete: queue it on a match, drop it otherwise
            state_d = FR_HUNT;
            pos_d   = '0;
            sum_d   = '0;
            if (pass) begin
              slot_d = ~slot_q;
            end
          end else begin
            sum_d = sum_q + rx_byte_i;
            pos_d = pos_q + POS_W'(1);
            if (pos_q == POS_W'(ROUTE_IDX)) begin
              route_d = rx_byte_i[ROUTE_BIT];
            end
          end
        end
      end
      default: begin
        state_d = FR_HUNT;
        pos_d   = '0;
        sum_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_HUNT;
      pos_q   <= '0;
      sum_q   <= '0;
      slot_q  <= 1'b0;
      route_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      slot_q  <= slot_d;
      route_q <= route_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/cfrr_desc_q.sv
// Two-entry queue of checked frame descriptors between receive and emit sides.
// Depends on cfrr_pkg.
`default_nettype none

module cfrr_desc_q
  import cfrr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire desc_t desc_i,
  input  wire logic  pop_i,
  output logic       valid_o,
  output desc_t      head_o,
  output logic [1:0] count_o
);

  desc_t      ent_q [DESC_DEPTH];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

>>> sv/cfrr_back.sv
// Emit side: walks one queued frame, reads the frame buffer, builds the output
// bytes and trailing sum, and buffers them in a two-entry output FIFO. Depends on cfrr_pkg.
`default_nettype none

module cfrr_back
  import cfrr_pkg::*;
#(
  parameter int IN_LEN  = 16,
  parameter int OUT_LEN = 15,
  parameter int ADDR_W  = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire desc_t             q_head_i,
  output logic                   q_pop_o,
  output bk_stat_t               stat_o,
  input  wire logic [7:0]        out_start_i,
  output logic                   rd_en_o,
  output logic [ADDR_W-1:0]      rd_addr_o,
  input  wire logic [7:0]        rd_data_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_last_o,
  output logic                   route_wired_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i
);

  localparam int K_W   = $clog2(OUT_LEN);
  localparam int IDX_W = $clog2(OUT_LEN + 1);
  localparam int AW    = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_EMIT = 2'b10
  } bk_state_e;

  bk_state_e       state_q;
  logic [K_W-1:0]  k_q;
  logic            slot_q;
  logic            route_q;

  logic            vb_q, firstb_q, lastb_q, zerob_q, routeb_q;
  logic [7:0]      sum_q;
  logic [7:0]      v;

  logic [7:0]      fb_byte_q  [2];
  logic            fb_last_q  [2];
  logic            fb_route_q [2];
  logic            fwp_q, frp_q;
  logic [1:0]      fcnt_q;

  logic            pop;
  logic            issue;
  logic            last_k;
  logic [IDX_W-1:0] idx;
  logic [AW-1:0]   full_addr;
  logic            in_rng;

  assign pop    = out_valid_o & out_ready_i;
  // Room for one more byte counting the read in flight and a pop this cycle
  assign issue  = (state_q == BK_EMIT) &&
                  ((3'(fcnt_q) + 3'(vb_q)) < (3'd2 + 3'(pop)));
  assign last_k = (k_q == K_W'(OUT_LEN - 1));
  assign idx    = IDX_W'(k_q) + IDX_W'(1);
  assign in_rng = (AW'(idx) < AW'(IN_LEN));
  assign full_addr = AW'(idx) + (slot_q ? AW'(IN_LEN) : '0);

  assign rd_en_o     = issue & in_rng;
  assign rd_addr_o   = ADDR_W'(full_addr);
  assign q_pop_o     = (state_q == BK_IDLE) & q_valid_i;
  assign stat_o.busy = (state_q == BK_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      k_q     <= '0;
      slot_q  <= 1'b0;
      route_q <= 1'b0;
    end else begin
      case (state_q)
        BK_IDLE: begin
          if (q_valid_i) begin
            state_q <= BK_EMIT;
            k_q     <= '0;
            slot_q  <= q_head_i.slot;
            route_q <= q_head_i.route;
          end
        end
        BK_EMIT: begin
          if (issue) begin
            k_q <= k_q + K_W'(1);
            if (last_k) begin
              state_q <= BK_IDLE;
            end
          end
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

  // Byte stage: read data is valid in the cycle after issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      firstb_q <= (k_q == '0);
      lastb_q  <= last_k;
      zerob_q  <= ~in_rng;
      routeb_q <= route_q;
    end
  end

  always_comb begin
    if (firstb_q) begin
      v = out_start_i;
    end else if (lastb_q) begin
      v = sum_q;
    end else if (zerob_q) begin
      v = 8'd0;
    end else begin
      v = rd_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (vb_q) begin
      sum_q <= firstb_q ? v : (sum_q + v);
    end
  end

  // Output FIFO
  always_ff @(posedge clk_i) begin
    if (vb_q) begin
      fb_byte_q[fwp_q]  <= v;
      fb_last_q[fwp_q]  <= lastb_q;
      fb_route_q[fwp_q] <= routeb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwp_q  <= 1'b0;
      frp_q  <= 1'b0;
      fcnt_q <= 2'd0;
    end else begin
      if (vb_q) begin
        fwp_q <= ~fwp_q;
      end
      if (pop) begin
        frp_q <= ~frp_q;
      end
      fcnt_q <= fcnt_q + 2'(vb_q) - 2'(pop);
    end
  end

  assign out_valid_o   = (fcnt_q != 2'd0);
  assign out_byte_o    = fb_byte_q[frp_q];
  assign out_last_o    = fb_last_q[frp_q];
  assign route_wired_o = fb_route_q[frp_q];

endmodule

`default_nettype wire

>>> sv/checksum_frame_receive_reframe.sv
// Fixed-length frame receiver with additive checksum and re-framer, top level.
// Intake: one byte per cycle while a frame buffer slot is free; two slots alternate.
// Path: a passing frame is queued, popped by the idle emitter, read, then buffered.
// Output: one byte per cycle from the emitter while out_ready_i is high, pausing between
//   frames for the emitter's idle state that pops the next frame descriptor.
// Reset (rst_ni low, asynchronous): hunting, queues empty, start bytes 0xA5.
`default_nettype none

module checksum_frame_receive_reframe
  import cfrr_pkg::*;
#(
  parameter int IN_LEN  = 16,
  parameter int OUT_LEN = 15
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // receive channel
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  // re-framed output channel
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            route_wired_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  // Two frame slots of IN_LEN bytes each
  localparam int ADDR_W = $clog2(2 * IN_LEN);
  localparam int DEPTH  = 2 * IN_LEN;

  logic [7:0]        in_start_q, out_start_q;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data_q;
  logic [7:0]        frame_mem [DEPTH];

  logic              push;
  desc_t             push_desc;
  logic              q_pop;
  logic              q_valid;
  desc_t             q_head;
  logic [1:0]        q_count;
  bk_stat_t          bk_stat;
  logic              slot_free;

  // Configuration registers; a write takes effect at the next edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_start_q  <= START_RESET;
      out_start_q <= START_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IN_START:  in_start_q  <= cfg_wdata_i;
        CFG_OUT_START: out_start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A slot is held from descriptor push until the emitter's last read;
  // the receiver may fill its current slot only while fewer than two are held
  assign slot_free = (q_count + 2'(bk_stat.busy)) < 2'd2;

  // Frame buffer: one write port from the receiver, one registered read port
  // for the emitter
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  cfrr_front #(
    .IN_LEN (IN_LEN),
    .ADDR_W (ADDR_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .slot_free_i (slot_free),
    .in_start_i  (in_start_q),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  cfrr_desc_q u_desc_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head),
    .count_o (q_count)
  );

  cfrr_back #(
    .IN_LEN  (IN_LEN),
    .OUT_LEN (OUT_LEN),
    .ADDR_W  (ADDR_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .stat_o        (bk_stat),
    .out_start_i   (out_start_q),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data_q),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o),
    .route_wired_o (route_wired_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

`default_nettype wire

>>> sv/cfrr_checker.sv
// Port-level checks for the re-framer output channel, bound to the top level.
// Depends on checksum_frame_receive_reframe.
`default_nettype none

module cfrr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i,
  input wire logic       route_wired_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i
);

  logic       acc;
  logic [7:0] sum_q;
  logic       mid_q;
  logic       route_q;

  assign acc = out_valid_i & out_ready_i;

  // Track the sum and route of bytes already taken in the current frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      mid_q   <= 1'b0;
      route_q <= 1'b0;
    end else if (acc) begin
      sum_q   <= out_last_i ? 8'd0 : (sum_q + out_byte_i);
      mid_q   <= ~out_last_i;
      route_q <= route_wired_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i))
    else $error("output transaction changed while stalled");

  a_trailer_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && out_last_i |-> out_byte_i == sum_q)
    else $error("closing byte is not the sum of the frame");

  a_route_const: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && mid_q |-> route_wired_i == route_q)
    else $error("route flag changed inside a frame");

endmodule

bind checksum_frame_receive_reframe cfrr_checker u_cfrr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_byte_i    (out_byte_o),
  .out_last_i    (out_last_o),
  .route_wired_i (route_wired_o),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i)
);

`default_nettype wire

>>> dv/checksum_frame_receive_reframe_tb.sv
// Self-checking testbench for checksum_frame_receive_reframe.
// Depends on cfrr_pkg and the block's top level; a built-in frame predictor checks
// every output byte.
`timescale 1ns / 1ps

module checksum_frame_receive_reframe_tb
  import cfrr_pkg::*;
();

  localparam int IN_LEN       = 16;
  localparam int OUT_LEN      = 15;
  // Extra wait after every expected byte has been taken, as a margin for the block to settle.
  localparam int DRAIN_CYCLES = 8;
  // Idle cycles in a row, with no transaction on either channel, before giving up.
  localparam int WATCHDOG_MAX = 1000;
  localparam int STALL_PCT    = 23;

  // One byte of the re-framed output as the checker expects it
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       route;
  } out_beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       rx_valid_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = CFG_IN_START;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       rx_ready_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;
  logic       route_wired_o;
  logic       out_valid_o;

  checksum_frame_receive_reframe #(
    .IN_LEN (IN_LEN),
    .OUT_LEN(OUT_LEN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .route_wired_o(route_wired_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: a private copy of the frame store, position, sum and registers
  logic [7:0] frame_buf [IN_LEN];
  int         frame_pos;
  logic [7:0] frame_acc;
  logic [7:0] in_start_reg;
  logic [7:0] out_start_reg;
  out_beat_t  expected_beats[$];

  // Frame under construction on the send side
  logic [7:0] tx_frame [IN_LEN];

  bit no_stall = 1'b0;
  int mismatches = 0;
  int bytes_sent = 0;
  int frames_passed = 0;
  int frames_dropped = 0;
  int beats_checked = 0;
  int idle_cycles = 0;

  // Advance the predictor by one accepted receive byte; queue any re-framed output.
  function automatic void predict_reframe(input logic [7:0] b);
    logic [7:0] out_sum;
    logic       route;
    out_beat_t  beat;
    int         k;
    if (frame_pos == 0) begin
      // Hunting: anything but the start byte is ignored
      if (b == in_start_reg) begin
        frame_buf[0] = b;
        frame_acc    = b;
        frame_pos    = 1;
      end
    end else if (frame_pos < IN_LEN - 1) begin
      frame_buf[frame_pos] = b;
      frame_acc            = frame_acc + b;
      frame_pos            = frame_pos + 1;
    end else begin
      // Checksum byte: emit on a match, drop the frame silently otherwise
      frame_buf[IN_LEN-1] = b;
      frame_pos           = 0;
      if (b == frame_acc) begin
        frames_passed = frames_passed + 1;
        route   = (ROUTE_IDX < IN_LEN) ? frame_buf[ROUTE_IDX][ROUTE_BIT] : 1'b0;
        out_sum = 8'h00;
        for (k = 0; k < OUT_LEN; k++) begin
          if (k == 0)
            beat.data = out_start_reg;
          else if (k < OUT_LEN - 1)
            beat.data = (k + 1 < IN_LEN) ? frame_buf[k+1] : 8'h00;
          else
            beat.data = out_sum;
          beat.last  = (k == OUT_LEN - 1);
          beat.route = route;
          out_sum    = out_sum + beat.data;
          expected_beats.push_back(beat);
        end
      end else begin
        frames_dropped = frames_dropped + 1;
      end
      frame_acc = 8'h00;
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("ERROR at %0t: %s got 0x%02h, want 0x%02h", $realtime, field, got, want);
    mismatches = mismatches + 1;
  endtask

  // Compare every output transaction with the oldest expected byte.
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected out_byte", out_byte_o, 8'h00);
      end else begin
        want = expected_beats.pop_front();
        beats_checked = beats_checked + 1;
        if (out_byte_o !== want.data)
          report_mismatch("out_byte", out_byte_o, want.data);
        if (out_last_o !== want.last)
          report_mismatch("out_last", {7'd0, out_last_o}, {7'd0, want.last});
        if (route_wired_o !== want.route)
          report_mismatch("route_wired", {7'd0, route_wired_o}, {7'd0, want.route});
      end
    end
  end

  // Output side back-pressure; hold ready high through a no-stall stretch.
  always @(negedge clk_i) begin
    out_ready_i <= no_stall || ($urandom_range(99) >= STALL_PCT);
  end

  // Abort when neither channel completes a transaction for too long.
  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Watchdog: no transaction for %0d cycles, pending %0d bytes",
               idle_cycles, expected_beats.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one receive byte: maybe insert a random gap first, then hold valid until accepted.
  task automatic drive_rx_byte(input logic [7:0] b);
    int gap;
    @(negedge clk_i);
    if (!no_stall && $urandom_range(99) < STALL_PCT) begin
      gap = $urandom_range(1, 4);
      rx_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_byte_i  <= b;
    rx_valid_i <= 1'b1;
    do @(posedge clk_i); while (!rx_ready_o);
    bytes_sent = bytes_sent + 1;
    predict_reframe(b);
  endtask

  // Drop valid, wait for every expected byte, then let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one start-byte register; only called while the block is idle.
  task automatic write_start_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_IN_START)
      in_start_reg = val;
    else
      out_start_reg = val;
  endtask

  // Send tx_frame with the current start byte and a checksum; corrupt it on request.
  task automatic send_frame(input bit corrupt);
    logic [7:0] sum;
    int         i;
    tx_frame[0] = in_start_reg;
    sum = 8'h00;
    for (i = 0; i < IN_LEN - 1; i++) sum = sum + tx_frame[i];
    tx_frame[IN_LEN-1] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
    for (i = 0; i < IN_LEN; i++) drive_rx_byte(tx_frame[i]);
  endtask

  task automatic fill_random_body();
    int i;
    for (i = 1; i < IN_LEN - 1; i++) tx_frame[i] = 8'($urandom);
  endtask

  // A byte that cannot open a frame while hunting
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == in_start_reg) b = b ^ 8'h01;
    return b;
  endfunction

  // Finish any partial frame so the block is back to hunting.
  task automatic close_open_frame();
    while (frame_pos != 0) drive_rx_byte(8'($urandom));
  endtask

  // Mostly well-formed frames with random content, plus bad checksums, cut-off
  // frames and noise between frames.
  task automatic run_random_traffic(input int sequences);
    int n;
    int pick;
    int i;
    for (n = 0; n < sequences; n++) begin
      pick = $urandom_range(99);
      fill_random_body();
      if (pick < 65) begin
        send_frame(1'b0);
      end else if (pick < 80) begin
        send_frame(1'b1);
      end else if (pick < 90) begin
        // Cut a frame short; following bytes land inside it
        drive_rx_byte(in_start_reg);
        for (i = $urandom_range(1, IN_LEN - 2); i > 0; i--) drive_rx_byte(8'($urandom));
      end else begin
        for (i = $urandom_range(1, 4); i > 0; i--) drive_rx_byte(noise_byte());
      end
    end
    close_open_frame();
  endtask

  // Reset values: ignored bytes while hunting, a passing frame with extreme
  // bytes and the wired flag, and a frame with a bad checksum.
  task automatic test_reset_defaults();
    int i;
    drive_rx_byte(8'h00);
    drive_rx_byte(8'hFF);
    drive_rx_byte(START_RESET ^ 8'h01);
    for (i = 1; i < IN_LEN - 1; i++) tx_frame[i] = i[0] ? 8'hFF : 8'h00;
    if (ROUTE_IDX < IN_LEN - 1) tx_frame[ROUTE_IDX] = 8'h80;
    send_frame(1'b0);
    fill_random_body();
    if (ROUTE_IDX < IN_LEN - 1) tx_frame[ROUTE_IDX][ROUTE_BIT] = 1'b0;
    send_frame(1'b1);
    wait_idle();
  endtask

  // Extreme and random start bytes on both registers, random traffic under each.
  task automatic test_start_bytes();
    logic [7:0] in_vals  [3];
    logic [7:0] out_vals [3];
    int p;
    in_vals[0]  = 8'h00;  out_vals[0] = 8'hFF;
    in_vals[1]  = 8'hFF;  out_vals[1] = 8'h00;
    in_vals[2]  = 8'($urandom);
    out_vals[2] = 8'($urandom);
    for (p = 0; p < 3; p++) begin
      write_start_reg(CFG_IN_START, in_vals[p]);
      write_start_reg(CFG_OUT_START, out_vals[p]);
      run_random_traffic(2);
      wait_idle();
    end
  endtask

  // Back-to-back frames with both sides always ready, to fill both frame slots.
  task automatic test_back_to_back();
    int n;
    write_start_reg(CFG_IN_START, START_RESET);
    write_start_reg(CFG_OUT_START, 8'($urandom));
    no_stall = 1'b1;
    for (n = 0; n < 3; n++) begin
      fill_random_body();
      send_frame(1'b0);
    end
    wait_idle();
    no_stall = 1'b0;
  endtask

  initial begin
    int i;
    for (i = 0; i < IN_LEN; i++) frame_buf[i] = 8'h00;
    frame_pos     = 0;
    frame_acc     = 8'h00;
    in_start_reg  = START_RESET;
    out_start_reg = START_RESET;

    // Hold reset low, then release it on a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_start_bytes();
    test_back_to_back();

    $display("Summary: %0d bytes sent, %0d frames passed, %0d dropped, %0d bytes checked",
             bytes_sent, frames_passed, frames_dropped, beats_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
